### design/lzw_byte_compressor_top_assert.svh
// assertion macros for the lzw byte compressor
`ifndef LZW_BYTE_COMPRESSOR_TOP_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LZW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LZW_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LZW_ASSERT(name, prop, msg)
`define LZW_ASSERT_RST(name, prop, msg)
`endif
`endif

### design/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg
// shared constants and types of the lzw byte compressor
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_WIDTH   = 12;
    localparam int OUT_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int FIRST_FREE   = 256;
    localparam int CODE_LIMIT   = (DICT_ENTRIES < (1 << CODE_WIDTH)) ?
                                  DICT_ENTRIES : (1 << CODE_WIDTH);
    localparam int FREE_W       = $clog2(CODE_LIMIT + 1);
    localparam int KEY_W        = CODE_WIDTH + BYTE_W;
    localparam int CELL_AW      = 5;
    localparam int CELL_ENTRIES = 1 << CELL_AW;
    localparam int NUM_CELLS    = (CODE_LIMIT - FIRST_FREE) / CELL_ENTRIES;

    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [CODE_WIDTH-1:0] code;
    } lzw_tok_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT_MISS,
        S_EMIT_LAST
    } lzw_state_t;

endpackage

### design/lzw_cell.sv
// ----------------------------------------------------------------------------
// lzw_cell
// one slice of the dictionary: holds a block of entries, compares them
// against the search key and passes the search token to the next cell
// ----------------------------------------------------------------------------
module lzw_cell
    import lzw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FREE_W-1:0]     base_code,
    input  logic [FREE_W-1:0]     next_free,
    input  logic [KEY_W-1:0]      key,
    input  logic                  wr_en,
    input  logic [FREE_W-1:0]     wr_code,
    input  logic [KEY_W-1:0]      wr_key,
    input  lzw_tok_t              tok_in,
    output lzw_tok_t              tok_out
);

    logic [KEY_W-1:0]      entries_reg [CELL_ENTRIES];
    logic                  local_hit;
    logic [CODE_WIDTH-1:0] local_code;
    logic [FREE_W-1:0]     entry_code;
    logic                  wr_sel;
    lzw_tok_t              tok_reg;
    lzw_tok_t              tok_next;

    assign wr_sel = wr_en && (wr_code[FREE_W-1:CELL_AW] == base_code[FREE_W-1:CELL_AW]);

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            entries_reg[wr_code[CELL_AW-1:0]] <= wr_key;
        end
    end

    always_comb
    begin
        local_hit  = 1'b0;
        local_code = '0;
        entry_code = '0;
        for (int k = 0; k < CELL_ENTRIES; k++)
        begin
            entry_code = base_code + FREE_W'(k);
            if ((entry_code < next_free) && (entries_reg[k] == key))
            begin
                local_hit  = 1'b1;
                local_code = entry_code[CODE_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | local_hit;
        tok_next.code  = tok_in.hit ? tok_in.code : local_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### design/lzw_byte_compressor_top.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_top
// lzw compressor of byte strings into 12-bit codes
// ----------------------------------------------------------------------------
// One byte is taken per input beat. The first byte of a string becomes
// the match (or, at end of string, the final code). Every further byte
// sends a search token down the chain of 120 dictionary cells of 32
// entries each. in_stall is held during the search, each code beat that
// it emits (a miss code and, at end of string, the final code) and any
// output stall. The dictionary is cleared at end of string without a sweep.
module lzw_byte_compressor_top
    import lzw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_string,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  code,
    output logic              last_code
);

    `include "lzw_byte_compressor_top_assert.svh"

    lzw_state_t            state_reg, state_next;
    logic [CODE_WIDTH-1:0] match_reg, match_next;
    logic                  mvalid_reg, mvalid_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  eos_reg, eos_next;
    logic [CODE_WIDTH-1:0] code_reg, code_next;
    logic                  last_reg, last_next;
    logic                  launch_reg, launch_next;
    logic                  wr_en;
    logic [KEY_W-1:0]      key;
    lzw_tok_t              tok [NUM_CELLS+1];

    assign key = {match_reg, byte_reg};

    assign tok[0] = {launch_reg, 1'b0, {CODE_WIDTH{1'b0}}};

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        lzw_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .base_code (FREE_W'(FIRST_FREE + g * CELL_ENTRIES)),
            .next_free (free_reg),
            .key       (key),
            .wr_en     (wr_en),
            .wr_code   (free_reg),
            .wr_key    (key),
            .tok_in    (tok[g]),
            .tok_out   (tok[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            match_reg  <= '0;
            mvalid_reg <= 1'b0;
            free_reg   <= FREE_W'(FIRST_FREE);
            byte_reg   <= '0;
            eos_reg    <= 1'b0;
            code_reg   <= '0;
            last_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            match_reg  <= match_next;
            mvalid_reg <= mvalid_next;
            free_reg   <= free_next;
            byte_reg   <= byte_next;
            eos_reg    <= eos_next;
            code_reg   <= code_next;
            last_reg   <= last_next;
            launch_reg <= launch_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        match_next  = match_reg;
        mvalid_next = mvalid_reg;
        free_next   = free_reg;
        byte_next   = byte_reg;
        eos_next    = eos_reg;
        code_next   = code_reg;
        last_next   = last_reg;
        launch_next = 1'b0;
        wr_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_byte;
                    eos_next  = end_of_string;
                    if (!mvalid_reg)
                    begin
                        match_next  = CODE_WIDTH'(data_byte);
                        mvalid_next = 1'b1;
                        if (end_of_string)
                        begin
                            code_next   = CODE_WIDTH'(data_byte);
                            last_next   = 1'b1;
                            mvalid_next = 1'b0;
                            free_next   = FREE_W'(FIRST_FREE);
                            match_next  = '0;
                            state_next  = S_EMIT_LAST;
                        end
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (tok[NUM_CELLS].valid)
                begin
                    if (tok[NUM_CELLS].hit)
                    begin
                        match_next = tok[NUM_CELLS].code;
                        if (eos_reg)
                        begin
                            code_next   = tok[NUM_CELLS].code;
                            last_next   = 1'b1;
                            mvalid_next = 1'b0;
                            free_next   = FREE_W'(FIRST_FREE);
                            match_next  = '0;
                            state_next  = S_EMIT_LAST;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        code_next  = match_reg;
                        last_next  = 1'b0;
                        match_next = CODE_WIDTH'(byte_reg);
                        if (free_reg < FREE_W'(CODE_LIMIT))
                        begin
                            wr_en     = 1'b1;
                            free_next = free_reg + 1'b1;
                        end
                        state_next = S_EMIT_MISS;
                    end
                end
            end
            S_EMIT_MISS:
            begin
                if (!out_stall)
                begin
                    if (eos_reg)
                    begin
                        code_next   = match_reg;
                        last_next   = 1'b1;
                        mvalid_next = 1'b0;
                        free_next   = FREE_W'(FIRST_FREE);
                        match_next  = '0;
                        state_next  = S_EMIT_LAST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_LAST:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT_MISS) || (state_reg == S_EMIT_LAST);
    assign code      = OUT_W'(code_reg);
    assign last_code = last_reg;

    `LZW_ASSERT(a_token_in_search, tok[NUM_CELLS].valid |-> state_reg == S_SEARCH, "token outside search")
    `LZW_ASSERT_RST(a_free_bound, free_reg <= FREE_W'(CODE_LIMIT), "next free code beyond limit")
    `LZW_ASSERT(a_last_cleared, state_reg == S_EMIT_LAST |-> !mvalid_reg && free_reg == FREE_W'(FIRST_FREE), "dictionary not cleared at end of string")

endmodule
